/* rtl/ptbl_pkg.sv */
`default_nettype none
package ptbl_pkg;

	localparam int DIR_ENTRIES   = 1024;
	localparam int TABLE_ENTRIES = 1024;
	localparam int TABLE_POOL    = 16;

	localparam int DIR_W   = 10;
	localparam int TIDX_W  = 10;
	localparam int OFFS_W  = 12;
	localparam int FRAME_W = 20;
	localparam int TBL_W   = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int PG_AW   = TBL_W + TIDX_W;
	localparam int PG_DEPTH = TABLE_POOL * TABLE_ENTRIES;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_MAP       = 2'd1,
		KIND_UNMAP     = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_NOT_MAPPED = 2'd2,
		ST_POOL_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_TRANSLATE,
		OP_MAP,
		OP_UNMAP,
		OP_NOP,
		OP_MISALIGNED
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [DIR_W-1:0]    dir_idx;
		logic [TIDX_W-1:0]   tbl_idx;
		logic [OFFS_W-1:0]   offset;
		logic [FRAME_W-1:0]  frame;
		logic                user;
		logic                writable;
	} cmd_t;

	typedef struct packed {
		logic              present;
		logic [TBL_W-1:0]  tbl;
	} dir_entry_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               user;
		logic               write;
		logic               present;
	} page_entry_t;

	typedef struct packed {
		logic  push;
	} push_ctl_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_DIR,
		BK_CLEAR,
		BK_MAPW,
		BK_PAGE,
		BK_RESP
	} back_state_t;

endpackage
`default_nettype wire

/* rtl/ptbl_req_if.sv */
`default_nettype none
interface ptbl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic        user_access;
	logic        writable;

	modport source (output valid, kind, virt_addr, phys_addr, user_access, writable,
		input ready);
	modport sink (input valid, kind, virt_addr, phys_addr, user_access, writable,
		output ready);
endinterface
`default_nettype wire

/* rtl/ptbl_rsp_if.sv */
`default_nettype none
interface ptbl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] phys_result;
	logic        invalidate_tlb;

	modport source (output valid, status, phys_result, invalidate_tlb, input ready);
	modport sink (input valid, status, phys_result, invalidate_tlb, output ready);
endinterface
`default_nettype wire

/* rtl/ptbl_front.sv */
`default_nettype none
module ptbl_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ptbl_req_if.sink         req,
	output ptbl_pkg::push_ctl_t ctl_out,
	input  wire logic        push_ready,
	output ptbl_pkg::cmd_t   push_cmd
);

	logic            valid_s1;
	ptbl_pkg::cmd_t  cmd_s1;
	ptbl_pkg::cmd_t  cmd_c;
	logic            va_off_nz;
	logic            pa_off_nz;
	logic            take;

	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;
	assign push_cmd  = cmd_s1;
	assign ctl_out.push       = valid_s1;

	assign va_off_nz = req.virt_addr[ptbl_pkg::OFFS_W-1:0] != '0;
	assign pa_off_nz = req.phys_addr[ptbl_pkg::OFFS_W-1:0] != '0;

	always_comb begin
		cmd_c.dir_idx  = req.virt_addr[31:32-ptbl_pkg::DIR_W];
		cmd_c.tbl_idx  = req.virt_addr[ptbl_pkg::OFFS_W+ptbl_pkg::TIDX_W-1:ptbl_pkg::OFFS_W];
		cmd_c.offset   = req.virt_addr[ptbl_pkg::OFFS_W-1:0];
		cmd_c.frame    = req.phys_addr[31:ptbl_pkg::OFFS_W];
		cmd_c.user     = req.user_access;
		cmd_c.writable = req.writable;
		case (ptbl_pkg::kind_t'(req.kind))
			ptbl_pkg::KIND_TRANSLATE: begin
				cmd_c.op = ptbl_pkg::OP_TRANSLATE;
			end
			ptbl_pkg::KIND_MAP: begin
				cmd_c.op = (va_off_nz || pa_off_nz) ? ptbl_pkg::OP_MISALIGNED
					: ptbl_pkg::OP_MAP;
			end
			ptbl_pkg::KIND_UNMAP: begin
				cmd_c.op = va_off_nz ? ptbl_pkg::OP_MISALIGNED : ptbl_pkg::OP_UNMAP;
			end
			default: begin
				cmd_c.op = ptbl_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule
`default_nettype wire

/* rtl/ptbl_queue.sv */
`default_nettype none
module ptbl_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ptbl_pkg::push_ctl_t  ctl_in,
	input  wire ptbl_pkg::cmd_t       push_cmd,
	output logic                      push_ready,
	input  wire logic                 pop,
	output logic                      head_valid,
	output ptbl_pkg::cmd_t            head
);

	ptbl_pkg::cmd_t                 slots_q [ptbl_pkg::QUEUE_DEPTH];
	logic [ptbl_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ptbl_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ptbl_pkg::QPTR_W:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = count_q != (ptbl_pkg::QPTR_W+1)'(ptbl_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = ctl_in.push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* rtl/ptbl_back.sv */
`default_nettype none
module ptbl_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire ptbl_pkg::cmd_t  head,
	output logic                 pop,
	ptbl_rsp_if.source           rsp
);

	localparam logic [ptbl_pkg::DIR_W-1:0] DIR_LAST =
		ptbl_pkg::DIR_W'(ptbl_pkg::DIR_ENTRIES - 1);
	localparam logic [ptbl_pkg::DIR_W-1:0] TBL_LAST =
		ptbl_pkg::DIR_W'(ptbl_pkg::TABLE_ENTRIES - 1);

	ptbl_pkg::dir_entry_t   dir_mem [ptbl_pkg::DIR_ENTRIES];
	ptbl_pkg::page_entry_t  pg_mem  [ptbl_pkg::PG_DEPTH];

	ptbl_pkg::back_state_t  state_q, state_d;
	logic [ptbl_pkg::DIR_W-1:0]  cnt_q;
	logic [ptbl_pkg::TBL_W:0]    next_free_q;
	logic [ptbl_pkg::TBL_W-1:0]  tbl_q;
	ptbl_pkg::cmd_t              cur_q;
	ptbl_pkg::dir_entry_t        dir_rd_q;
	ptbl_pkg::page_entry_t       pg_rd_q;

	ptbl_pkg::status_t  res_status_q;
	logic [31:0]        res_phys_q;
	logic               res_inval_q;

	logic               rsp_valid_q;
	ptbl_pkg::status_t  rsp_status_q;
	logic [31:0]        rsp_phys_q;
	logic               rsp_inval_q;

	logic                        pool_empty;
	logic                        rsp_load;
	logic                        alloc;
	logic                        dir_we;
	logic [ptbl_pkg::DIR_W-1:0]  dir_wa;
	logic [ptbl_pkg::DIR_W-1:0]  dir_ra;
	ptbl_pkg::dir_entry_t        dir_wd;
	logic                        pg_we;
	logic [ptbl_pkg::PG_AW-1:0]  pg_wa;
	logic [ptbl_pkg::PG_AW-1:0]  pg_ra;
	ptbl_pkg::page_entry_t       pg_wd;
	ptbl_pkg::page_entry_t       map_entry;
	logic                        res_we;
	ptbl_pkg::status_t           res_status_d;
	logic [31:0]                 res_phys_d;
	logic                        res_inval_d;

	assign pool_empty = next_free_q >= (ptbl_pkg::TBL_W+1)'(ptbl_pkg::TABLE_POOL);
	assign rsp_load   = (state_q == ptbl_pkg::BK_RESP) && (!rsp_valid_q || rsp.ready);

	assign map_entry.frame   = cur_q.frame;
	assign map_entry.user    = cur_q.user;
	assign map_entry.write   = cur_q.writable;
	assign map_entry.present = 1'b1;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.phys_result    = rsp_phys_q;
	assign rsp.invalidate_tlb = rsp_inval_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptbl_pkg::BK_INIT: begin
				if (cnt_q == DIR_LAST) begin
					state_d = ptbl_pkg::BK_IDLE;
				end
			end
			ptbl_pkg::BK_IDLE: begin
				if (head_valid) begin
					state_d = (head.op == ptbl_pkg::OP_NOP || head.op == ptbl_pkg::OP_MISALIGNED)
						? ptbl_pkg::BK_RESP : ptbl_pkg::BK_DIR;
				end
			end
			ptbl_pkg::BK_DIR: begin
				case (cur_q.op)
					ptbl_pkg::OP_TRANSLATE: begin
						state_d = dir_rd_q.present ? ptbl_pkg::BK_PAGE : ptbl_pkg::BK_RESP;
					end
					ptbl_pkg::OP_MAP: begin
						state_d = (!dir_rd_q.present && !pool_empty) ? ptbl_pkg::BK_CLEAR
							: ptbl_pkg::BK_RESP;
					end
					default: begin
						state_d = ptbl_pkg::BK_RESP;
					end
				endcase
			end
			ptbl_pkg::BK_CLEAR: begin
				if (cnt_q == TBL_LAST) begin
					state_d = ptbl_pkg::BK_MAPW;
				end
			end
			ptbl_pkg::BK_MAPW: begin
				state_d = ptbl_pkg::BK_RESP;
			end
			ptbl_pkg::BK_PAGE: begin
				state_d = ptbl_pkg::BK_RESP;
			end
			ptbl_pkg::BK_RESP: begin
				if (rsp_load) begin
					state_d = ptbl_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ptbl_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop          = 1'b0;
		alloc        = 1'b0;
		dir_ra       = head.dir_idx;
		dir_we       = 1'b0;
		dir_wa       = cnt_q;
		dir_wd       = '0;
		pg_we        = 1'b0;
		pg_wa        = {tbl_q, cnt_q};
		pg_wd        = '0;
		pg_ra        = {dir_rd_q.tbl, cur_q.tbl_idx};
		res_we       = 1'b0;
		res_status_d = ptbl_pkg::ST_OK;
		res_phys_d   = '0;
		res_inval_d  = 1'b0;
		case (state_q)
			ptbl_pkg::BK_INIT: begin
				dir_we = 1'b1;
			end
			ptbl_pkg::BK_IDLE: begin
				pop = head_valid;
				if (head_valid) begin
					res_we = 1'b1;
					if (head.op == ptbl_pkg::OP_MISALIGNED) begin
						res_status_d = ptbl_pkg::ST_MISALIGNED;
					end
				end
			end
			ptbl_pkg::BK_DIR: begin
				case (cur_q.op)
					ptbl_pkg::OP_TRANSLATE: begin
						if (!dir_rd_q.present) begin
							res_we       = 1'b1;
							res_status_d = ptbl_pkg::ST_NOT_MAPPED;
						end
					end
					ptbl_pkg::OP_MAP: begin
						if (dir_rd_q.present) begin
							pg_we       = 1'b1;
							pg_wa       = {dir_rd_q.tbl, cur_q.tbl_idx};
							pg_wd       = map_entry;
							res_we      = 1'b1;
							res_inval_d = 1'b1;
						end else if (pool_empty) begin
							res_we       = 1'b1;
							res_status_d = ptbl_pkg::ST_POOL_EMPTY;
						end else begin
							alloc          = 1'b1;
							dir_we         = 1'b1;
							dir_wa         = cur_q.dir_idx;
							dir_wd.present = 1'b1;
							dir_wd.tbl     = next_free_q[ptbl_pkg::TBL_W-1:0];
						end
					end
					ptbl_pkg::OP_UNMAP: begin
						res_we = 1'b1;
						if (dir_rd_q.present) begin
							pg_we       = 1'b1;
							pg_wa       = {dir_rd_q.tbl, cur_q.tbl_idx};
							res_inval_d = 1'b1;
						end else begin
							res_status_d = ptbl_pkg::ST_NOT_MAPPED;
						end
					end
					default: begin
					end
				endcase
			end
			ptbl_pkg::BK_CLEAR: begin
				pg_we = 1'b1;
			end
			ptbl_pkg::BK_MAPW: begin
				pg_we       = 1'b1;
				pg_wa       = {tbl_q, cur_q.tbl_idx};
				pg_wd       = map_entry;
				res_we      = 1'b1;
				res_inval_d = 1'b1;
			end
			ptbl_pkg::BK_PAGE: begin
				res_we = 1'b1;
				if (pg_rd_q.present) begin
					res_phys_d = {pg_rd_q.frame, cur_q.offset};
				end else begin
					res_status_d = ptbl_pkg::ST_NOT_MAPPED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptbl_pkg::BK_INIT;
			cnt_q       <= '0;
			next_free_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alloc) begin
				cnt_q       <= '0;
				next_free_q <= next_free_q + 1'b1;
			end else if (state_q == ptbl_pkg::BK_INIT || state_q == ptbl_pkg::BK_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (alloc) begin
			tbl_q <= next_free_q[ptbl_pkg::TBL_W-1:0];
		end
		if (res_we) begin
			res_status_q <= res_status_d;
			res_phys_q   <= res_phys_d;
			res_inval_q  <= res_inval_d;
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_phys_q   <= res_phys_q;
			rsp_inval_q  <= res_inval_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		dir_rd_q <= dir_mem[dir_ra];
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			pg_mem[pg_wa] <= pg_wd;
		end
		pg_rd_q <= pg_mem[pg_ra];
	end

endmodule
`default_nettype wire

/* rtl/two_level_page_table_engine_unit.sv */
// Two-level page table engine for one 32-bit address space. Requests
// (translate, map, unmap) are taken into a four-entry command queue and
// carried out one at a time against a 1024-entry directory memory and a
// page-entry memory of 16 tables x 1024 entries; each request gets exactly
// one response, in order. An accepted request passes through the front-end
// register into the queue. From queue head to response register a translate
// walks directory read, page read, result and response load, a map or
// unmap directory read, result and response load, a misaligned or unused
// request result and response load; throughput is set by the back end
// walking these steps one request at a time. A map that has to allocate a
// table first clears its 1024 entries, then writes the page entry. After
// reset the engine clears all 1024 directory entries before it executes any
// request; the input still accepts requests until the queue fills.
`default_nettype none
module two_level_page_table_engine_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptbl_req_if.sink   req,
	ptbl_rsp_if.source rsp
);

	ptbl_pkg::push_ctl_t  ctl;
	ptbl_pkg::cmd_t       push_cmd;
	ptbl_pkg::cmd_t       head;
	logic                 push_ready;
	logic                 head_valid;
	logic                 pop;

	ptbl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.ctl_out    (ctl),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	ptbl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (ctl),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ptbl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

/* rtl/ptbl_checker.sv */
`default_nettype none
module ptbl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic [31:0] rsp_phys_result,
	input wire logic        rsp_invalidate_tlb
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_phys_result)
			&& $stable(rsp_invalidate_tlb))
		else $error("response changed while stalled");

	a_fail_no_inval: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ptbl_pkg::ST_OK |-> !rsp_invalidate_tlb
			&& rsp_phys_result == '0)
		else $error("failed request reports invalidate or address");

	a_addr_only_translate: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_invalidate_tlb |-> rsp_phys_result == '0)
		else $error("table update reports a translated address");

endmodule

bind two_level_page_table_engine_unit ptbl_checker u_ptbl_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_phys_result    (rsp.phys_result),
	.rsp_invalidate_tlb (rsp.invalidate_tlb)
);
`default_nettype wire

/* bench/page_table_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module page_table_checker
	import ptbl_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ptbl_req_if         req,
	ptbl_rsp_if         rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	typedef struct packed {
		status_t     status;
		logic [31:0] phys;
		logic        inval;
	} outcome_t;

	dir_entry_t  dir_model  [DIR_ENTRIES];
	page_entry_t page_model [PG_DEPTH];
	int unsigned tables_used;
	int unsigned mismatches;
	int unsigned rsp_count;
	outcome_t    awaited [$];

	function automatic outcome_t predict_walk(kind_t k, logic [31:0] va, logic [31:0] pa,
		logic usr, logic wr);
		outcome_t         o;
		logic [DIR_W-1:0] d;
		logic [PG_AW-1:0] slot;
		page_entry_t      pe;
		int               i;
		o = '{ST_OK, 32'd0, 1'b0};
		d = va[31:22];
		slot = {dir_model[d].tbl, va[21:12]};
		case (k)
			KIND_TRANSLATE: begin
				pe = page_model[slot];
				if (dir_model[d].present && pe.present)
					o.phys = {pe.frame, va[11:0]};
				else
					o.status = ST_NOT_MAPPED;
			end
			KIND_MAP: begin
				if (va[11:0] != 12'd0 || pa[11:0] != 12'd0) begin
					o.status = ST_MISALIGNED;
				end else if (!dir_model[d].present && tables_used >= TABLE_POOL) begin
					o.status = ST_POOL_EMPTY;
				end else begin
					if (!dir_model[d].present) begin
						for (i = 0; i < TABLE_ENTRIES; i++)
							page_model[tables_used * TABLE_ENTRIES + i] = '0;
						dir_model[d] = '{present: 1'b1, tbl: TBL_W'(tables_used)};
						tables_used++;
						slot = {dir_model[d].tbl, va[21:12]};
					end
					page_model[slot] = '{frame: pa[31:12], user: usr, write: wr, present: 1'b1};
					o.inval = 1'b1;
				end
			end
			KIND_UNMAP: begin
				if (va[11:0] != 12'd0) begin
					o.status = ST_MISALIGNED;
				end else if (dir_model[d].present) begin
					page_model[slot] = '0;
					o.inval = 1'b1;
				end else begin
					o.status = ST_NOT_MAPPED;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		if (!arst_n) begin
			foreach (dir_model[i])
				dir_model[i] = '0;
			tables_used = 0;
			mismatches = 0;
			rsp_count = 0;
			awaited.delete();
		end else begin
			if (req.valid && req.ready)
				awaited.push_back(predict_walk(kind_t'(req.kind), req.virt_addr, req.phys_addr,
					req.user_access, req.writable));
			if (rsp.valid && rsp.ready) begin
				rsp_count++;
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response %0d arrived with nothing pending", $time,
							rsp_count);
				end else begin
					exp_o = awaited.pop_front();
					if (rsp.status !== exp_o.status || rsp.phys_result !== exp_o.phys ||
						rsp.invalidate_tlb !== exp_o.inval) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: response %0d got status %0d phys %h inval %b, ",
								$time, rsp_count, rsp.status, rsp.phys_result,
								rsp.invalidate_tlb);
							$display("wanted status %0d phys %h inval %b",
								exp_o.status, exp_o.phys, exp_o.inval);
						end
					end
				end
			end
		end
		fail_count <= mismatches;
		outstanding <= awaited.size();
	end

endmodule
`default_nettype wire

/* bench/tb_two_level_page_table_engine_unit.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_two_level_page_table_engine_unit;
	import ptbl_pkg::*;

	localparam int STALL_LIMIT  = 8000;
	localparam int PHASE_ITEMS  = 610;
	localparam int DIR_CHOICES  = 20;

	logic             clk;
	logic             arst_n;
	int unsigned      fail_count;
	int unsigned      outstanding;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	logic [DIR_W-1:0] dir_choice [DIR_CHOICES];

	ptbl_req_if req ();
	ptbl_rsp_if rsp ();

	two_level_page_table_engine_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	page_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_req(kind_t k, logic [31:0] va, logic [31:0] pa, logic usr, logic wr);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.virt_addr <= va;
		req.phys_addr <= pa;
		req.user_access <= usr;
		req.writable <= wr;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain_responses();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_req();
		int unsigned pick;
		logic [31:0] va;
		logic [31:0] pa;
		kind_t       k;
		pick = $urandom_range(99);
		va = {dir_choice[$urandom_range(DIR_CHOICES - 1)],
			($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7)), 12'h000};
		pa = {20'($urandom), 12'h000};
		if (pick < 40) begin
			k = KIND_TRANSLATE;
			va[11:0] = 12'($urandom);
		end else if (pick < 75) begin
			k = KIND_MAP;
		end else if (pick < 88) begin
			k = KIND_UNMAP;
		end else begin
			// noise: any kind, misaligned or scattered addresses
			k = kind_t'(2'($urandom_range(3)));
			if ($urandom_range(1) == 1)
				va = $urandom;
			else
				va[11:0] = 12'($urandom);
			pa = $urandom;
		end
		send_req(k, va, pa, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= KIND_TRANSLATE;
		req.virt_addr <= 32'd0;
		req.phys_addr <= 32'd0;
		req.user_access <= 1'b0;
		req.writable <= 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 51;
		foreach (dir_choice[i])
			dir_choice[i] = 10'($urandom);
		dir_choice[0] = '0;
		dir_choice[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_req(KIND_TRANSLATE, 32'h0000_0000, 32'h0, 1'b0, 1'b0);
		send_req(KIND_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_req(KIND_MAP, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1);
		send_req(KIND_MAP, 32'h0000_0000, 32'h0000_0800, 1'b0, 1'b1);
		send_req(KIND_UNMAP, 32'h0040_0FFF, 32'h0, 1'b0, 1'b0);
		send_req(KIND_UNMAP, 32'h4000_0000, 32'h0, 1'b0, 1'b0);
		send_req(KIND_MAP, 32'h0000_0000, 32'hFFFF_F000, 1'b1, 1'b1);
		send_req(KIND_TRANSLATE, 32'h0000_0FFF, 32'h0, 1'b0, 1'b0);
		send_req(KIND_MAP, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b0);
		send_req(KIND_TRANSLATE, 32'h0000_1ABC, 32'h0, 1'b0, 1'b0);
		send_req(KIND_MAP, 32'hFFFF_F000, 32'h8000_1000, 1'b0, 1'b1);
		send_req(KIND_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		send_req(KIND_TRANSLATE, 32'hFFC0_0000, 32'h0, 1'b0, 1'b0);
		send_req(KIND_UNMAP, 32'h0000_2000, 32'h0, 1'b0, 1'b0);
		send_req(KIND_UNMAP, 32'h0000_0000, 32'h0, 1'b1, 1'b1);
		send_req(KIND_TRANSLATE, 32'h0000_0123, 32'h0, 1'b0, 1'b0);
		send_req(KIND_MAP, 32'h0000_1000, 32'h7FFF_F000, 1'b1, 1'b0);
		send_req(KIND_TRANSLATE, 32'h0000_1000, 32'h0, 1'b0, 1'b0);
		send_req(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_req(KIND_NONE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_req(KIND_MAP, 32'h003F_F000, 32'h5555_5000, 1'b1, 1'b1);
		send_req(KIND_TRANSLATE, 32'h003F_F555, 32'h0, 1'b0, 1'b0);
		drain_responses();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 51 : 0;
			recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 34 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_req();
			drain_responses();
		end

		repeat (30) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
